@@ hw/rtl/dtlc_pkg.sv @@
// Shared types, constants and microcode for the decision tree leaf counter.
// Depends on nothing; every other file refers to it by scoped names.
package dtlc_pkg;

  localparam int NODE_COUNT    = 256;
  localparam int NODE_BITS     = $clog2(NODE_COUNT);
  localparam int FEATURE_COUNT = 16;
  localparam int FEAT_BITS     = $clog2(FEATURE_COUNT);
  localparam int VALUE_BITS    = 16;
  localparam int COUNT_BITS    = 16;
  localparam int ACTION_BITS   = 3;
  localparam int STEP_BITS     = $clog2(NODE_COUNT + 1);
  localparam int LEAF_CAP      = (NODE_COUNT - 1) < 255 ? (NODE_COUNT - 1) : 255;
  localparam int RANK_BITS     = 8;
  localparam int UPC_BITS      = 4;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // command codes
  typedef enum logic [ACTION_BITS-1:0] {
    ACT_WNODE    = 3'd0,
    ACT_WFEAT    = 3'd1,
    ACT_CLASSIFY = 3'd2,
    ACT_READ     = 3'd3,
    ACT_CLEAR    = 3'd4
  } action_t;

  // node table read source
  typedef enum logic [1:0] {NRD_NONE, NRD_ROOT, NRD_STEP} nrd_t;
  // count store read address source
  typedef enum logic [1:0] {CRD_NONE, CRD_ORD, CRD_QUERY} crd_t;
  // jump conditions
  typedef enum logic [1:0] {COND_NONE, COND_MORE, COND_MISS} cond_t;
  // result word format
  typedef enum logic [2:0] {RES_NONE, RES_ZERO, RES_LEAF, RES_READ, RES_ERR} res_t;

  typedef logic [UPC_BITS-1:0] upc_t;

  // one control word
  typedef struct packed {
    nrd_t  nrd;
    crd_t  crd;
    logic  node_wr;
    logic  feat_wr;
    logic  cnt_inc;
    logic  cnt_clr;
    res_t  res;
    cond_t cond;
    upc_t  target;
    logic  last;
  } ctrl_t;

  // walk status back to the sequencer
  typedef struct packed {
    logic hit;
    logic bound;
  } stat_t;

  // node table entry with its leaf rank
  typedef struct packed {
    logic                  leaf;
    logic [RANK_BITS-1:0]  rank;
    logic [FEAT_BITS-1:0]  feat;
    logic [VALUE_BITS-1:0] value;
    logic [NODE_BITS-1:0]  left;
    logic [NODE_BITS-1:0]  right;
  } node_t;

  // microprogram addresses
  localparam upc_t U_WNODE = 4'd0;
  localparam upc_t U_WFEAT = 4'd1;
  localparam upc_t U_CL0   = 4'd2;
  localparam upc_t U_CL1   = 4'd3;
  localparam upc_t U_CL2   = 4'd4;
  localparam upc_t U_CL3   = 4'd5;
  localparam upc_t U_CL4   = 4'd6;
  localparam upc_t U_CLERR = 4'd7;
  localparam upc_t U_RD0   = 4'd8;
  localparam upc_t U_RD1   = 4'd9;
  localparam upc_t U_CLR   = 4'd10;
  localparam upc_t U_NOP   = 4'd11;

  localparam ctrl_t IDLE_CTRL = '{nrd: NRD_NONE, crd: CRD_NONE, node_wr: 1'b0,
                                  feat_wr: 1'b0, cnt_inc: 1'b0, cnt_clr: 1'b0,
                                  res: RES_NONE, cond: COND_NONE, target: U_NOP,
                                  last: 1'b0};

  // microprogram ROM
  function automatic ctrl_t ucode_rom(input upc_t pc);
    ctrl_t w;
    w = IDLE_CTRL;
    unique case (pc)
      U_WNODE: begin w.node_wr = 1'b1; w.res = RES_ZERO; w.last = 1'b1; end
      U_WFEAT: begin w.feat_wr = 1'b1; w.res = RES_ZERO; w.last = 1'b1; end
      U_CL0:   w.nrd = NRD_ROOT;
      U_CL1:   begin w.nrd = NRD_STEP; w.cond = COND_MORE; w.target = U_CL1; end
      U_CL2:   begin w.cond = COND_MISS; w.target = U_CLERR; end
      U_CL3:   w.crd = CRD_ORD;
      U_CL4:   begin w.cnt_inc = 1'b1; w.res = RES_LEAF; w.last = 1'b1; end
      U_CLERR: begin w.res = RES_ERR; w.last = 1'b1; end
      U_RD0:   w.crd = CRD_QUERY;
      U_RD1:   begin w.res = RES_READ; w.last = 1'b1; end
      U_CLR:   begin w.cnt_clr = 1'b1; w.res = RES_ZERO; w.last = 1'b1; end
      default: begin w.res = RES_ZERO; w.last = 1'b1; end
    endcase
    return w;
  endfunction

  // entry point of each command
  function automatic upc_t entry_of(input logic [ACTION_BITS-1:0] act);
    upc_t e;
    unique case (act)
      ACT_WNODE:    e = U_WNODE;
      ACT_WFEAT:    e = U_WFEAT;
      ACT_CLASSIFY: e = U_CL0;
      ACT_READ:     e = U_RD0;
      ACT_CLEAR:    e = U_CLR;
      default:      e = U_NOP;
    endcase
    return e;
  endfunction

endpackage

@@ hw/rtl/dtlc_sequencer.sv @@
// Microprogram sequencer: step counter, ROM fetch and conditional jumps.
// Depends on dtlc_pkg for the control word, ROM and entry table.
module dtlc_sequencer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [dtlc_pkg::ACTION_BITS-1:0]  action,
  input  dtlc_pkg::stat_t                   stat,
  output logic                              busy,
  output dtlc_pkg::ctrl_t                   ctl
);

  dtlc_pkg::upc_t  pc;
  dtlc_pkg::ctrl_t word;
  logic            taken;

  // fetch
  assign word = dtlc_pkg::ucode_rom(pc);
  assign ctl  = busy ? word : dtlc_pkg::IDLE_CTRL;

  // jump condition
  always_comb begin
    case (word.cond)
      dtlc_pkg::COND_MORE: taken = !stat.hit && !stat.bound;
      dtlc_pkg::COND_MISS: taken = !stat.hit;
      default:             taken = 1'b0;
    endcase
  end

  // step counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= dtlc_pkg::U_NOP;
    end else if (!busy) begin
      if (start) begin
        busy <= 1'b1;
        pc   <= dtlc_pkg::entry_of(action);
      end
    end else begin
      if (word.last) busy <= 1'b0;
      pc <= taken ? word.target : pc + 1'b1;
    end
  end

endmodule

@@ hw/rtl/dtlc_datapath.sv @@
// Datapath: command latch, node table, feature slots, count store and result word.
// Depends on dtlc_pkg; driven by the control word from dtlc_sequencer.
module dtlc_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  dtlc_pkg::ctrl_t                    ctl,
  input  logic [dtlc_pkg::NODE_BITS-1:0]     node_index,
  input  logic [dtlc_pkg::FEAT_BITS-1:0]     split_feature,
  input  logic [dtlc_pkg::VALUE_BITS-1:0]    split_value,
  input  logic [dtlc_pkg::NODE_BITS-1:0]     left_child,
  input  logic [dtlc_pkg::NODE_BITS-1:0]     right_child,
  input  logic                               is_leaf,
  input  logic [dtlc_pkg::FEAT_BITS-1:0]     feature_index,
  input  logic [dtlc_pkg::VALUE_BITS-1:0]    feature_value,
  input  logic [dtlc_pkg::NODE_BITS-1:0]     query_slot,
  output dtlc_pkg::stat_t                    stat,
  output logic                               done,
  output logic [dtlc_pkg::NODE_BITS-1:0]     leaf_node,
  output logic [dtlc_pkg::RANK_BITS-1:0]     leaf_ordinal,
  output logic [dtlc_pkg::COUNT_BITS-1:0]    leaf_count,
  output logic                               walk_error
);

  // latched command word
  logic [dtlc_pkg::NODE_BITS-1:0]  c_node_index;
  logic [dtlc_pkg::FEAT_BITS-1:0]  c_split_feature;
  logic [dtlc_pkg::VALUE_BITS-1:0] c_split_value;
  logic [dtlc_pkg::NODE_BITS-1:0]  c_left_child;
  logic [dtlc_pkg::NODE_BITS-1:0]  c_right_child;
  logic                            c_is_leaf;
  logic [dtlc_pkg::FEAT_BITS-1:0]  c_feature_index;
  logic [dtlc_pkg::VALUE_BITS-1:0] c_feature_value;
  logic [dtlc_pkg::NODE_BITS-1:0]  c_query_slot;

  always_ff @(posedge clk) begin
    if (load) begin
      c_node_index    <= node_index;
      c_split_feature <= split_feature;
      c_split_value   <= split_value;
      c_left_child    <= left_child;
      c_right_child   <= right_child;
      c_is_leaf       <= is_leaf;
      c_feature_index <= feature_index;
      c_feature_value <= feature_value;
      c_query_slot    <= query_slot;
    end
  end

  // leaf numbering; writing the root restarts it
  logic [dtlc_pkg::STEP_BITS-1:0] next_rank;
  logic [dtlc_pkg::STEP_BITS-1:0] rank_base;
  logic [dtlc_pkg::RANK_BITS-1:0] rank_new;

  assign rank_base = (c_node_index == '0) ? '0 : next_rank;
  assign rank_new  = (rank_base < dtlc_pkg::STEP_BITS'(dtlc_pkg::LEAF_CAP))
                     ? rank_base[dtlc_pkg::RANK_BITS-1:0]
                     : dtlc_pkg::RANK_BITS'(dtlc_pkg::LEAF_CAP);

  always_ff @(posedge clk) begin
    if (rst) begin
      next_rank <= '0;
    end else if (ctl.node_wr) begin
      if (c_is_leaf && rank_base <= dtlc_pkg::STEP_BITS'(dtlc_pkg::LEAF_CAP))
        next_rank <= rank_base + 1'b1;
      else
        next_rank <= rank_base;
    end
  end

  // feature slots
  logic [dtlc_pkg::VALUE_BITS-1:0] feat_regs [dtlc_pkg::FEATURE_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dtlc_pkg::FEATURE_COUNT; i++) feat_regs[i] <= '0;
    end else if (ctl.feat_wr) begin
      feat_regs[c_feature_index] <= c_feature_value;
    end
  end

  // node table, one registered read per level
  dtlc_pkg::node_t                 node_mem [dtlc_pkg::NODE_COUNT];
  dtlc_pkg::node_t                 node_q;
  dtlc_pkg::node_t                 wr_node;
  logic [dtlc_pkg::NODE_BITS-1:0]  cur;
  logic [dtlc_pkg::STEP_BITS-1:0]  steps;
  logic [dtlc_pkg::NODE_BITS-1:0]  nxt;
  logic [dtlc_pkg::NODE_BITS-1:0]  rd_addr;
  logic                            rd_en;
  logic                            go_right;

  assign wr_node = '{leaf: c_is_leaf, rank: c_is_leaf ? rank_new : '0,
                     feat: c_split_feature, value: c_split_value,
                     left: c_left_child, right: c_right_child};

  // walk status: root is never taken as a leaf; bound after the full node count of steps
  assign stat.hit   = (steps != '0) && node_q.leaf;
  assign stat.bound = (steps == dtlc_pkg::STEP_BITS'(dtlc_pkg::NODE_COUNT));

  assign go_right = feat_regs[node_q.feat] > node_q.value;
  assign nxt      = go_right ? node_q.right : node_q.left;
  assign rd_en    = (ctl.nrd == dtlc_pkg::NRD_ROOT) ||
                    (ctl.nrd == dtlc_pkg::NRD_STEP && !stat.hit && !stat.bound);
  assign rd_addr  = (ctl.nrd == dtlc_pkg::NRD_ROOT) ? '0 : nxt;

  always_ff @(posedge clk) begin
    if (ctl.node_wr) node_mem[c_node_index] <= wr_node;
    if (rd_en) node_q <= node_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur   <= rd_addr;
      steps <= (ctl.nrd == dtlc_pkg::NRD_ROOT) ? '0 : steps + 1'b1;
    end
  end

  // count store with per-entry valid bits; a clear drops them all
  logic [dtlc_pkg::COUNT_BITS-1:0] cnt_mem [dtlc_pkg::NODE_COUNT];
  logic [dtlc_pkg::NODE_COUNT-1:0] cnt_vld;
  logic [dtlc_pkg::COUNT_BITS-1:0] cnt_q;
  logic                            vld_q;
  logic [dtlc_pkg::NODE_BITS-1:0]  cnt_addr;
  logic [dtlc_pkg::NODE_BITS-1:0]  cnt_addr_q;
  logic [dtlc_pkg::NODE_BITS-1:0]  leaf_q;
  logic [dtlc_pkg::COUNT_BITS-1:0] cnt_cur;
  logic [dtlc_pkg::COUNT_BITS-1:0] cnt_inc_val;

  assign cnt_addr    = (ctl.crd == dtlc_pkg::CRD_ORD) ? node_q.rank : c_query_slot;
  assign cnt_cur     = vld_q ? cnt_q : '0;
  assign cnt_inc_val = (cnt_cur == dtlc_pkg::COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;

  always_ff @(posedge clk) begin
    if (ctl.crd != dtlc_pkg::CRD_NONE) begin
      cnt_q      <= cnt_mem[cnt_addr];
      vld_q      <= cnt_vld[cnt_addr];
      cnt_addr_q <= cnt_addr;
      leaf_q     <= cur;
    end
    if (ctl.cnt_inc) cnt_mem[cnt_addr_q] <= cnt_inc_val;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.cnt_clr) cnt_vld <= '0;
    else if (ctl.cnt_inc)   cnt_vld[cnt_addr_q] <= 1'b1;
  end

  // result word: strobe reset, payload held
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= (ctl.res != dtlc_pkg::RES_NONE);
  end

  always_ff @(posedge clk) begin
    case (ctl.res)
      dtlc_pkg::RES_LEAF: begin
        leaf_node    <= leaf_q;
        leaf_ordinal <= cnt_addr_q;
        leaf_count   <= cnt_inc_val;
        walk_error   <= 1'b0;
      end
      dtlc_pkg::RES_READ: begin
        leaf_node    <= '0;
        leaf_ordinal <= cnt_addr_q;
        leaf_count   <= cnt_cur;
        walk_error   <= 1'b0;
      end
      dtlc_pkg::RES_ERR: begin
        leaf_node    <= '0;
        leaf_ordinal <= '0;
        leaf_count   <= '0;
        walk_error   <= 1'b1;
      end
      dtlc_pkg::RES_ZERO: begin
        leaf_node    <= '0;
        leaf_ordinal <= '0;
        leaf_count   <= '0;
        walk_error   <= 1'b0;
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/decision_tree_leaf_counter.sv @@
// Top level of the decision tree leaf counter: sequencer plus datapath.
// Depends on dtlc_pkg, dtlc_sequencer and dtlc_datapath.
//
//   channel   handshake            word
//   command   start / busy         action, node and feature fields, query_slot
//   result    done (one cycle)     leaf_node, leaf_ordinal, leaf_count, walk_error
//
// A command is taken when start is high and busy low; done marks its result
// for one cycle, rising as busy falls. A classify makes one node table read per
// level below the root. Synchronous reset clears the counts at once through
// per-entry valid bits. The result side cannot stall; each result must be taken
// when shown.
module decision_tree_leaf_counter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [dtlc_pkg::ACTION_BITS-1:0]   action,
  input  logic [dtlc_pkg::NODE_BITS-1:0]     node_index,
  input  logic [dtlc_pkg::FEAT_BITS-1:0]     split_feature,
  input  logic [dtlc_pkg::VALUE_BITS-1:0]    split_value,
  input  logic [dtlc_pkg::NODE_BITS-1:0]     left_child,
  input  logic [dtlc_pkg::NODE_BITS-1:0]     right_child,
  input  logic                               is_leaf,
  input  logic [dtlc_pkg::FEAT_BITS-1:0]     feature_index,
  input  logic [dtlc_pkg::VALUE_BITS-1:0]    feature_value,
  input  logic [dtlc_pkg::NODE_BITS-1:0]     query_slot,
  output logic                               done,
  output logic [dtlc_pkg::NODE_BITS-1:0]     leaf_node,
  output logic [dtlc_pkg::RANK_BITS-1:0]     leaf_ordinal,
  output logic [dtlc_pkg::COUNT_BITS-1:0]    leaf_count,
  output logic                               walk_error
);

  dtlc_pkg::ctrl_t ctl;
  dtlc_pkg::stat_t stat;
  logic            load;

  // command accepted
  assign load = start && !busy;

  dtlc_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .stat   (stat),
    .busy   (busy),
    .ctl    (ctl)
  );

  dtlc_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .load          (load),
    .ctl           (ctl),
    .node_index    (node_index),
    .split_feature (split_feature),
    .split_value   (split_value),
    .left_child    (left_child),
    .right_child   (right_child),
    .is_leaf       (is_leaf),
    .feature_index (feature_index),
    .feature_value (feature_value),
    .query_slot    (query_slot),
    .stat          (stat),
    .done          (done),
    .leaf_node     (leaf_node),
    .leaf_ordinal  (leaf_ordinal),
    .leaf_count    (leaf_count),
    .walk_error    (walk_error)
  );

endmodule

@@ hw/rtl/dtlc_checker.sv @@
// Port-level checks for the decision tree leaf counter, bound to its top level.
// Depends on dtlc_pkg for widths and on decision_tree_leaf_counter for the bind.
module dtlc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             done,
  input logic [dtlc_pkg::NODE_BITS-1:0]   leaf_node,
  input logic [dtlc_pkg::RANK_BITS-1:0]   leaf_ordinal,
  input logic [dtlc_pkg::COUNT_BITS-1:0]  leaf_count,
  input logic                             walk_error
);

  // a taken command always sets busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("command taken without going busy");

  // a result shows only when a command has just finished
  a_done_end: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("result strobe not at end of command");

  // result strobes are single cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // a failed walk carries an all-zero leaf word
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && walk_error |-> leaf_node == '0 && leaf_ordinal == '0 && leaf_count == '0)
    else $error("walk error with non-zero leaf fields");

endmodule

bind decision_tree_leaf_counter dtlc_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .leaf_node    (leaf_node),
  .leaf_ordinal (leaf_ordinal),
  .leaf_count   (leaf_count),
  .walk_error   (walk_error)
);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for decision_tree_leaf_counter: a model of the tree in
// the bench predicts every result word and a checker compares each one as it comes.
// Depends on dtlc_pkg and the RTL top level only.
module testbench;

  localparam int NODE_COUNT    = dtlc_pkg::NODE_COUNT;
  localparam int NODE_BITS     = dtlc_pkg::NODE_BITS;
  localparam int FEATURE_COUNT = dtlc_pkg::FEATURE_COUNT;
  localparam int FEAT_BITS     = dtlc_pkg::FEAT_BITS;
  localparam int VALUE_BITS    = dtlc_pkg::VALUE_BITS;
  localparam int COUNT_BITS    = dtlc_pkg::COUNT_BITS;
  localparam int RANK_BITS     = dtlc_pkg::RANK_BITS;
  localparam int ACTION_BITS   = dtlc_pkg::ACTION_BITS;
  localparam int LEAF_CAP      = dtlc_pkg::LEAF_CAP;
  localparam int VALUE_MAX     = (1 << VALUE_BITS) - 1;
  localparam int COUNT_TOP     = (1 << COUNT_BITS) - 1;

  // first of the command codes that the block ignores
  localparam logic [ACTION_BITS-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [ACTION_BITS-1:0] ACT_SPARE_LAST  = 3'd7;

  localparam int RANDOM_WORDS   = 600;
  localparam int REPEAT_HITS    = 48;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int IDLE_PERCENT   = 15;

  // one command word as driven on the ports
  typedef struct packed {
    logic [ACTION_BITS-1:0] action;
    logic [NODE_BITS-1:0]   node_index;
    logic [FEAT_BITS-1:0]   split_feature;
    logic [VALUE_BITS-1:0]  split_value;
    logic [NODE_BITS-1:0]   left_child;
    logic [NODE_BITS-1:0]   right_child;
    logic                   is_leaf;
    logic [FEAT_BITS-1:0]   feature_index;
    logic [VALUE_BITS-1:0]  feature_value;
    logic [NODE_BITS-1:0]   query_slot;
  } command_t;

  // one result word
  typedef struct packed {
    logic [NODE_BITS-1:0]  node;
    logic [RANK_BITS-1:0]  ordinal;
    logic [COUNT_BITS-1:0] count;
    logic                  err;
  } outcome_t;

  // bench copy of one node table entry
  typedef struct packed {
    logic [FEAT_BITS-1:0]  feat;
    logic [VALUE_BITS-1:0] thresh;
    logic [NODE_BITS-1:0]  lo_child;
    logic [NODE_BITS-1:0]  hi_child;
    logic                  leaf;
    logic [RANK_BITS-1:0]  ordinal;
  } tree_entry_t;

  // outcome of a walk over the bench tree, without side effects
  typedef struct packed {
    logic                 safe;
    logic                 found;
    logic [NODE_BITS-1:0] node;
  } walk_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [ACTION_BITS-1:0] action;
  logic [NODE_BITS-1:0]   node_index;
  logic [FEAT_BITS-1:0]   split_feature;
  logic [VALUE_BITS-1:0]  split_value;
  logic [NODE_BITS-1:0]   left_child;
  logic [NODE_BITS-1:0]   right_child;
  logic                   is_leaf;
  logic [FEAT_BITS-1:0]   feature_index;
  logic [VALUE_BITS-1:0]  feature_value;
  logic [NODE_BITS-1:0]   query_slot;
  logic                   done;
  logic [NODE_BITS-1:0]   leaf_node;
  logic [RANK_BITS-1:0]   leaf_ordinal;
  logic [COUNT_BITS-1:0]  leaf_count;
  logic                   walk_error;

  // bench model of the tree, features and counts
  tree_entry_t           tree_tbl     [NODE_COUNT];
  bit                    node_written [NODE_COUNT];
  int unsigned           next_ordinal;
  logic [VALUE_BITS-1:0] feature_mem  [FEATURE_COUNT];
  logic [COUNT_BITS-1:0] count_mem    [NODE_COUNT];
  int                    tree_size;

  outcome_t pending_outcomes[$];

  bit idle_enabled;
  int mismatches;
  int stall_cycles;
  int words_counted;
  int n_node_writes, n_feat_writes, n_classifies, n_hits, n_walk_errors;
  int n_reads, n_clears, n_saturated;

  decision_tree_leaf_counter uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .node_index    (node_index),
    .split_feature (split_feature),
    .split_value   (split_value),
    .left_child    (left_child),
    .right_child   (right_child),
    .is_leaf       (is_leaf),
    .feature_index (feature_index),
    .feature_value (feature_value),
    .query_slot    (query_slot),
    .done          (done),
    .leaf_node     (leaf_node),
    .leaf_ordinal  (leaf_ordinal),
    .leaf_count    (leaf_count),
    .walk_error    (walk_error)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // walk from the root as the block does; flags any touch of an unwritten node
  function automatic walk_t walk_tree();
    walk_t w;
    int    k;
    int    nxt;
    w = '0;
    w.safe = 1'b1;
    k = 0;
    for (int steps = 0; steps < NODE_COUNT; steps++) begin
      if (!node_written[k]) begin
        w.safe = 1'b0;
        return w;
      end
      nxt = (feature_mem[tree_tbl[k].feat] > tree_tbl[k].thresh) ?
            tree_tbl[k].hi_child : tree_tbl[k].lo_child;
      if (!node_written[nxt]) begin
        w.safe = 1'b0;
        return w;
      end
      k = nxt;
      if (tree_tbl[k].leaf) begin
        w.found = 1'b1;
        w.node = NODE_BITS'(k);
        return w;
      end
    end
    // bound reached without a leaf
    return w;
  endfunction

  // update the bench model for one accepted word and return its result word
  function automatic outcome_t apply_command(command_t c);
    outcome_t    r;
    walk_t       w;
    tree_entry_t e;
    int          ord;
    r = '0;
    case (c.action)
      dtlc_pkg::ACT_WNODE: begin
        n_node_writes++;
        if (c.node_index == 0) next_ordinal = 0;
        e.feat = c.split_feature;
        e.thresh = c.split_value;
        e.lo_child = c.left_child;
        e.hi_child = c.right_child;
        e.leaf = c.is_leaf;
        if (c.is_leaf) begin
          e.ordinal = RANK_BITS'((next_ordinal < LEAF_CAP) ? next_ordinal : LEAF_CAP);
          if (next_ordinal <= LEAF_CAP) next_ordinal++;
        end else begin
          e.ordinal = '0;
        end
        tree_tbl[c.node_index] = e;
        node_written[c.node_index] = 1'b1;
      end
      dtlc_pkg::ACT_WFEAT: begin
        n_feat_writes++;
        feature_mem[c.feature_index] = c.feature_value;
      end
      dtlc_pkg::ACT_CLASSIFY: begin
        n_classifies++;
        w = walk_tree();
        if (w.found) begin
          n_hits++;
          ord = tree_tbl[w.node].ordinal;
          if (count_mem[ord] < COUNT_TOP) count_mem[ord]++;
          else n_saturated++;
          r.node = w.node;
          r.ordinal = RANK_BITS'(ord);
          r.count = count_mem[ord];
        end else begin
          n_walk_errors++;
          r.err = 1'b1;
        end
      end
      dtlc_pkg::ACT_READ: begin
        n_reads++;
        r.ordinal = c.query_slot;
        r.count = count_mem[c.query_slot];
      end
      dtlc_pkg::ACT_CLEAR: begin
        n_clears++;
        foreach (count_mem[i]) count_mem[i] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // all fields random, so unused fields toggle too
  function automatic command_t random_word();
    command_t c;
    c.action = ACTION_BITS'($urandom_range(ACT_SPARE_LAST, 0));
    c.node_index = NODE_BITS'($urandom_range(NODE_COUNT - 1, 0));
    c.split_feature = FEAT_BITS'($urandom_range(FEATURE_COUNT - 1, 0));
    c.split_value = VALUE_BITS'($urandom_range(VALUE_MAX, 0));
    c.left_child = NODE_BITS'($urandom_range(NODE_COUNT - 1, 0));
    c.right_child = NODE_BITS'($urandom_range(NODE_COUNT - 1, 0));
    c.is_leaf = ($urandom_range(1, 0) == 1);
    c.feature_index = FEAT_BITS'($urandom_range(FEATURE_COUNT - 1, 0));
    c.feature_value = VALUE_BITS'($urandom_range(VALUE_MAX, 0));
    c.query_slot = NODE_BITS'($urandom_range(NODE_COUNT - 1, 0));
    return c;
  endfunction

  function automatic command_t node_word(int idx, int feat, int thresh, int lo, int hi,
                                         bit leaf);
    command_t c;
    c = random_word();
    c.action = dtlc_pkg::ACT_WNODE;
    c.node_index = idx[NODE_BITS-1:0];
    c.split_feature = feat[FEAT_BITS-1:0];
    c.split_value = thresh[VALUE_BITS-1:0];
    c.left_child = lo[NODE_BITS-1:0];
    c.right_child = hi[NODE_BITS-1:0];
    c.is_leaf = leaf;
    return c;
  endfunction

  function automatic command_t feature_word(int slot, int value);
    command_t c;
    c = random_word();
    c.action = dtlc_pkg::ACT_WFEAT;
    c.feature_index = slot[FEAT_BITS-1:0];
    c.feature_value = value[VALUE_BITS-1:0];
    return c;
  endfunction

  // classify, read, clear or a spare code
  function automatic command_t plain_word(logic [ACTION_BITS-1:0] act, int slot);
    command_t c;
    c = random_word();
    c.action = act;
    c.query_slot = slot[NODE_BITS-1:0];
    return c;
  endfunction

  // feature values that sit on, just above and just below thresholds
  function automatic int pick_feature_value();
    int r;
    int v;
    r = $urandom_range(9, 0);
    if (r == 4) return 0;
    if (r == 5) return VALUE_MAX;
    if (r < 4 || tree_size == 0) return $urandom_range(VALUE_MAX, 0);
    v = tree_tbl[$urandom_range(tree_size - 1, 0)].thresh;
    v = v + $urandom_range(2, 0) - 1;
    return v & VALUE_MAX;
  endfunction

  // drive one word at the falling edge and hold it until the block takes it
  task automatic send_word(command_t c);
    if (idle_enabled && $urandom_range(99, 0) < IDLE_PERCENT) begin
      repeat ($urandom_range(6, 1)) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    @(negedge clk);
    start <= 1'b1;
    action <= c.action;
    node_index <= c.node_index;
    split_feature <= c.split_feature;
    split_value <= c.split_value;
    left_child <= c.left_child;
    right_child <= c.right_child;
    is_leaf <= c.is_leaf;
    feature_index <= c.feature_index;
    feature_value <= c.feature_value;
    query_slot <= c.query_slot;
    do @(posedge clk); while (busy);
    pending_outcomes.push_back(apply_command(c));
    if (c.action < ACT_SPARE_FIRST) words_counted++;
  endtask

  // classify only when the walk stays on written nodes; else move a feature
  task automatic classify_or_nudge();
    walk_t w;
    w = walk_tree();
    if (w.safe) send_word(plain_word(dtlc_pkg::ACT_CLASSIFY, 0));
    else send_word(feature_word($urandom_range(FEATURE_COUNT - 1, 0), pick_feature_value()));
  endtask

  // small hand-built tree: threshold edges, every command, root as a leaf, loop
  task automatic test_directed();
    idle_enabled = 1'b1;
    send_word(plain_word(dtlc_pkg::ACT_READ, 0));
    send_word(plain_word(dtlc_pkg::ACT_READ, NODE_COUNT - 1));
    send_word(node_word(0, 3, 100, 1, 2, 1'b0));
    send_word(node_word(1, 0, 0, 0, 0, 1'b1));
    send_word(node_word(2, FEATURE_COUNT - 1, 0, 3, 4, 1'b0));
    send_word(node_word(3, 0, VALUE_MAX, 0, 0, 1'b1));
    send_word(node_word(4, 0, 0, NODE_COUNT - 1, NODE_COUNT - 1, 1'b1));
    tree_size = 5;
    send_word(plain_word(dtlc_pkg::ACT_CLASSIFY, 0));
    // equal to the threshold goes left, one above goes right
    send_word(feature_word(3, 100));
    send_word(plain_word(dtlc_pkg::ACT_CLASSIFY, 0));
    send_word(feature_word(3, 101));
    send_word(plain_word(dtlc_pkg::ACT_CLASSIFY, 0));
    send_word(feature_word(FEATURE_COUNT - 1, VALUE_MAX));
    send_word(plain_word(dtlc_pkg::ACT_CLASSIFY, 0));
    send_word(plain_word(dtlc_pkg::ACT_READ, 2));
    for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
      send_word(plain_word(ACTION_BITS'(a), 0));
    send_word(plain_word(dtlc_pkg::ACT_CLEAR, 0));
    send_word(plain_word(dtlc_pkg::ACT_READ, 0));
    // nothing exceeds the top threshold; root rewrite restarts the numbering
    send_word(node_word(0, 0, VALUE_MAX, 1, 2, 1'b0));
    send_word(feature_word(0, VALUE_MAX));
    send_word(plain_word(dtlc_pkg::ACT_CLASSIFY, 0));
    // a split that points at itself runs into the walk bound
    send_word(node_word(1, 0, 0, 1, 1, 1'b0));
    send_word(plain_word(dtlc_pkg::ACT_CLASSIFY, 0));
    // root marked as leaf is still split first, then found through child 0
    send_word(node_word(0, 0, VALUE_MAX, 0, 0, 1'b1));
    send_word(plain_word(dtlc_pkg::ACT_CLASSIFY, 0));
  endtask

  // fill the whole table with leaves so the ordinal runs into its cap
  task automatic test_rank_cap();
    idle_enabled = 1'b1;
    send_word(node_word(0, $urandom_range(FEATURE_COUNT - 1, 0),
                        $urandom_range(VALUE_MAX, 0), 1, NODE_COUNT - 1, 1'b0));
    for (int i = 1; i < NODE_COUNT; i++) begin
      send_word(node_word(i, $urandom_range(FEATURE_COUNT - 1, 0),
                          $urandom_range(VALUE_MAX, 0), $urandom_range(NODE_COUNT - 1, 0),
                          $urandom_range(NODE_COUNT - 1, 0), 1'b1));
    end
    tree_size = NODE_COUNT;
    // out-of-order rewrites past the cap keep the top ordinal
    send_word(node_word(NODE_COUNT / 2, 0, 0, 0, 0, 1'b1));
    send_word(node_word(NODE_COUNT - 1, 0, 0, 0, 0, 1'b1));
    send_word(node_word(1, 0, 0, 0, 0, 1'b1));
    for (int i = 0; i < 8; i++) begin
      send_word(feature_word($urandom_range(FEATURE_COUNT - 1, 0), pick_feature_value()));
      send_word(plain_word(dtlc_pkg::ACT_CLASSIFY, 0));
    end
    send_word(plain_word(dtlc_pkg::ACT_READ, LEAF_CAP));
    send_word(plain_word(dtlc_pkg::ACT_READ, LEAF_CAP - 1));
  endtask

  // one leaf hit over and over from a cleared count; back to back, no idling
  task automatic test_repeat_hits();
    idle_enabled = 1'b0;
    send_word(node_word(0, 0, VALUE_MAX, 1, 1, 1'b0));
    send_word(node_word(1, 0, 0, 0, 0, 1'b1));
    tree_size = 2;
    send_word(plain_word(dtlc_pkg::ACT_CLEAR, 0));
    repeat (REPEAT_HITS) send_word(plain_word(dtlc_pkg::ACT_CLASSIFY, 0));
    send_word(plain_word(dtlc_pkg::ACT_READ, 0));
    send_word(plain_word(dtlc_pkg::ACT_CLEAR, 0));
  endtask

  // random trees written in node order, then mixed traffic over them
  task automatic test_random_trees();
    int  first;
    int  n;
    int  r;
    int  lo;
    int  hi;
    int  thresh;
    bit  leaf;
    first = words_counted;
    while (words_counted - first < RANDOM_WORDS) begin
      idle_enabled = ($urandom_range(5, 0) != 0);
      n = ($urandom_range(9, 0) == 0) ? $urandom_range(64, 25) : $urandom_range(24, 3);
      for (int i = 0; i < n; i++) begin
        leaf = (i == n - 1) ? 1'b1 : (i == 0) ? 1'b0 : ($urandom_range(99, 0) < 40);
        lo = (i < n - 1) ? $urandom_range(n - 1, i + 1) : 0;
        hi = (i < n - 1) ? $urandom_range(n - 1, i + 1) : 0;
        // the odd back edge may close a loop
        if (!leaf && $urandom_range(19, 0) == 0) hi = $urandom_range(n - 1, 0);
        r = $urandom_range(3, 0);
        thresh = (r == 0) ? 0 : (r == 1) ? VALUE_MAX : $urandom_range(VALUE_MAX, 0);
        send_word(node_word(i, $urandom_range(FEATURE_COUNT - 1, 0), thresh, lo, hi, leaf));
      end
      tree_size = n;
      for (int f = 0; f < FEATURE_COUNT; f++) send_word(feature_word(f, pick_feature_value()));
      repeat ($urandom_range(80, 40)) begin
        r = $urandom_range(99, 0);
        if (r < 45) begin
          classify_or_nudge();
        end else if (r < 65) begin
          send_word(feature_word($urandom_range(FEATURE_COUNT - 1, 0), pick_feature_value()));
        end else if (r < 75) begin
          send_word(plain_word(dtlc_pkg::ACT_READ, $urandom_range(1, 0) ?
                               $urandom_range(NODE_COUNT - 1, 0) :
                               $urandom_range(tree_size, 0)));
        end else if (r < 78) begin
          send_word(plain_word(dtlc_pkg::ACT_CLEAR, 0));
        end else if (r < 83) begin
          send_word(plain_word(ACTION_BITS'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST)),
                               0));
        end else if (r < 93) begin
          // rewrite inside the tree, children kept on written nodes
          send_word(node_word($urandom_range(n - 1, 0), $urandom_range(FEATURE_COUNT - 1, 0),
                              $urandom_range(VALUE_MAX, 0), $urandom_range(n - 1, 0),
                              $urandom_range(n - 1, 0), $urandom_range(99, 0) < 40));
        end else begin
          send_word(node_word($urandom_range(NODE_COUNT - 1, 0),
                              $urandom_range(FEATURE_COUNT - 1, 0),
                              $urandom_range(VALUE_MAX, 0), $urandom_range(NODE_COUNT - 1, 0),
                              $urandom_range(NODE_COUNT - 1, 0), $urandom_range(1, 0) == 1));
        end
      end
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // every strobed result word against the oldest prediction
  always @(posedge clk) begin : result_check
    outcome_t want;
    if (!rst && done) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t ns: unexpected result word, expected none, actual node %0d ord %0d",
                 $time, leaf_node, leaf_ordinal);
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("leaf_node", want.node, leaf_node);
        check_field("leaf_ordinal", want.ordinal, leaf_ordinal);
        check_field("leaf_count", want.count, leaf_count);
        check_field("walk_error", want.err, walk_error);
      end
    end
  end

  // cycles with no word taken and no result shown
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles", $time, stall_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    action = '0;
    node_index = '0;
    split_feature = '0;
    split_value = '0;
    left_child = '0;
    right_child = '0;
    is_leaf = 1'b0;
    feature_index = '0;
    feature_value = '0;
    query_slot = '0;
    mismatches = 0;
    words_counted = 0;
    idle_enabled = 1'b1;
    tree_size = 0;
    next_ordinal = 0;
    foreach (node_written[i]) node_written[i] = 1'b0;
    foreach (count_mem[i]) count_mem[i] = '0;
    foreach (feature_mem[i]) feature_mem[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_rank_cap();
    test_repeat_hits();
    test_random_trees();

    @(negedge clk);
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d words: %0d node writes, %0d feature writes, %0d classifies",
             words_counted, n_node_writes, n_feat_writes, n_classifies);
    $display("%0d leaf hits, %0d walk errors, %0d saturated hits, %0d reads, %0d clears",
             n_hits, n_walk_errors, n_saturated, n_reads, n_clears);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
